// ===== design/vps_pkg.sv =====
// vps_pkg: shared constants, command and viewport types, saturation helpers
// for the vertex projection block. No dependencies.
package vps_pkg;

  localparam int unsigned FRAC_BITS_DEF   = 16;
  localparam int unsigned COEF_WIDTH_DEF  = 32;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  localparam int unsigned WORD_W = 32;   // item fields
  localparam int unsigned OP_W   = 64;   // multiplier operands, combined matrix
  localparam int unsigned PROD_W = 128;  // products and accumulators
  localparam int unsigned R_W    = 98;   // transformed coordinates
  localparam int unsigned QUO_W  = 64;   // quotient
  localparam int unsigned CFG_W  = 16;
  localparam int unsigned VP_W   = 15;

  localparam logic [VP_W-1:0] VP_WIDTH_RST  = VP_W'(640);
  localparam logic [VP_W-1:0] VP_HEIGHT_RST = VP_W'(480);

  typedef enum logic [1:0] {
    REG_ORIGIN_X,
    REG_ORIGIN_Y,
    REG_WIDTH,
    REG_HEIGHT
  } cfg_reg_e;

  typedef enum logic {
    CMD_LOAD,
    CMD_POINT
  } cmd_kind_e;

  // a carries the coefficient for loads, x for points
  typedef struct packed {
    cmd_kind_e                kind;
    logic                     mat_sel;
    logic [3:0]               idx;
    logic signed [WORD_W-1:0] a;
    logic signed [WORD_W-1:0] b;
    logic signed [WORD_W-1:0] c;
  } cmd_t;

  typedef struct packed {
    logic signed [CFG_W-1:0] origin_x;
    logic signed [CFG_W-1:0] origin_y;
    logic [VP_W-1:0]         width;
    logic [VP_W-1:0]         height;
  } viewport_t;

  function automatic logic signed [OP_W-1:0] sat64(input logic signed [PROD_W-1:0] v);
    if (v[PROD_W-1:OP_W-1] == '0 || v[PROD_W-1:OP_W-1] == '1) begin
      return v[OP_W-1:0];
    end
    return v[PROD_W-1] ? {1'b1, {(OP_W-1){1'b0}}} : {1'b0, {(OP_W-1){1'b1}}};
  endfunction

  function automatic logic signed [WORD_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
    if (v[PROD_W-1:WORD_W-1] == '0 || v[PROD_W-1:WORD_W-1] == '1) begin
      return v[WORD_W-1:0];
    end
    return v[PROD_W-1] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
  endfunction

endpackage

// ===== design/vps_if.sv =====
// vps_in_if / vps_out_if: valid-ready channels of the vertex projection block.
// No dependencies.
interface vps_in_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic               matrix_select;
  logic [3:0]         coef_index;
  logic signed [31:0] coef_value;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;

  modport source (output valid, mode, matrix_select, coef_index, coef_value,
                  point_x, point_y, point_z, input ready);
  modport sink (input valid, mode, matrix_select, coef_index, coef_value,
                point_x, point_y, point_z, output ready);
endinterface

interface vps_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] screen_x;
  logic signed [31:0] screen_y;
  logic signed [31:0] depth_value;
  logic               w_zero;

  modport source (output valid, screen_x, screen_y, depth_value, w_zero, input ready);
  modport sink (input valid, screen_x, screen_y, depth_value, w_zero, output ready);
endinterface

// ===== design/vps_front.sv =====
// vps_front: input stage; takes item transfers, sorts them into load or point
// commands and registers them toward the queue. Uses vps_pkg, vps_in_if.
module vps_front import vps_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  vps_in_if.sink in_ch,
  output logic push_valid_o,
  input  logic push_ready_i,
  output cmd_t push_cmd_o
);

  logic valid_q;
  cmd_t cmd_q, cmd_d;

  assign in_ch.ready  = !valid_q || push_ready_i;
  assign push_valid_o = valid_q;
  assign push_cmd_o   = cmd_q;

  always_comb begin
    cmd_d = '0;
    if (in_ch.mode) begin
      cmd_d.kind = CMD_POINT;
      cmd_d.a    = in_ch.point_x;
      cmd_d.b    = in_ch.point_y;
      cmd_d.c    = in_ch.point_z;
    end else begin
      cmd_d.kind    = CMD_LOAD;
      cmd_d.mat_sel = in_ch.matrix_select;
      cmd_d.idx     = in_ch.coef_index;
      cmd_d.a       = in_ch.coef_value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ch.ready) begin
      valid_q <= in_ch.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch.valid && in_ch.ready) begin
      cmd_q <= cmd_d;
    end
  end

endmodule

// ===== design/vps_fifo.sv =====
// vps_fifo: short command queue between front and back (DEPTH >= 2).
// Uses vps_pkg.
module vps_fifo import vps_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_cmd_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output cmd_t pop_cmd_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;
  logic             push, pop;

  assign push_ready_o = cnt_q != CNT_W'(DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_cmd_o    = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_cmd_i;
    end
  end

endmodule

// ===== design/vps_mul.sv =====
// vps_mul: 64x64 signed multiplier built from one 32x32 unsigned multiplier,
// four partial products computed one after another. Uses vps_pkg.
module vps_mul import vps_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [OP_W-1:0]   a_i,
  input  logic signed [OP_W-1:0]   b_i,
  output logic                     done_o,
  output logic signed [PROD_W-1:0] p_o
);

  localparam int unsigned HALF_W = OP_W / 2;

  typedef enum logic [1:0] {M_IDLE, M_MUL, M_ADD, M_FIN} state_e;

  state_e              state_q;
  logic [1:0]          k_q, sh_q;
  logic                pv_q, neg_q, done_q;
  logic [OP_W-1:0]     ua_q, ub_q, pp_q;
  logic [PROD_W-1:0]   acc_q, pp_sh;
  logic [HALF_W-1:0]   a_part, b_part;
  logic signed [PROD_W-1:0] p_q;

  assign a_part = k_q[1] ? ua_q[OP_W-1:HALF_W] : ua_q[HALF_W-1:0];
  assign b_part = k_q[0] ? ub_q[OP_W-1:HALF_W] : ub_q[HALF_W-1:0];
  assign done_o = done_q;
  assign p_o    = p_q;

  always_comb begin
    case (sh_q)
      2'd0:    pp_sh = {{(PROD_W-OP_W){1'b0}}, pp_q};
      2'd1:    pp_sh = {{(PROD_W-OP_W-HALF_W){1'b0}}, pp_q, {HALF_W{1'b0}}};
      default: pp_sh = {pp_q, {(PROD_W-OP_W){1'b0}}};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
      k_q     <= '0;
      sh_q    <= '0;
      pv_q    <= 1'b0;
      neg_q   <= 1'b0;
      done_q  <= 1'b0;
      ua_q    <= '0;
      ub_q    <= '0;
      pp_q    <= '0;
      acc_q   <= '0;
      p_q     <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        M_IDLE: begin
          if (start_i) begin
            ua_q    <= a_i[OP_W-1] ? OP_W'(-a_i) : a_i;
            ub_q    <= b_i[OP_W-1] ? OP_W'(-b_i) : b_i;
            neg_q   <= a_i[OP_W-1] ^ b_i[OP_W-1];
            acc_q   <= '0;
            k_q     <= '0;
            pv_q    <= 1'b0;
            state_q <= M_MUL;
          end
        end
        M_MUL: begin
          pp_q <= a_part * b_part;
          sh_q <= 2'(k_q[1]) + 2'(k_q[0]);
          pv_q <= 1'b1;
          if (pv_q) begin
            acc_q <= acc_q + pp_sh;
          end
          k_q <= k_q + 1'b1;
          if (k_q == 2'd3) begin
            state_q <= M_ADD;
          end
        end
        M_ADD: begin
          acc_q   <= acc_q + pp_sh;
          state_q <= M_FIN;
        end
        M_FIN: begin
          p_q     <= neg_q ? PROD_W'(-acc_q) : acc_q;
          done_q  <= 1'b1;
          state_q <= M_IDLE;
        end
        default: state_q <= M_IDLE;
      endcase
    end
  end

endmodule

// ===== design/vps_div.sv =====
// vps_div: signed divide, round to nearest with ties away from zero,
// saturated to 64 bits; one quotient bit per cycle. Uses vps_pkg.
module vps_div import vps_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [R_W-1:0]   num_i,
  input  logic signed [R_W-1:0]   den_i,
  output logic                    done_o,
  output logic signed [QUO_W-1:0] q_o
);

  localparam int unsigned NUM_W = R_W + FRAC_BITS + 2;
  localparam int unsigned DSH_W = R_W + QUO_W;
  localparam int unsigned CMP_W = (NUM_W > DSH_W) ? NUM_W : DSH_W;
  localparam int unsigned CNT_W = $clog2(QUO_W);

  typedef enum logic [1:0] {D_IDLE, D_LOAD, D_ITER, D_FIN} state_e;

  state_e            state_q;
  logic [R_W-1:0]    un_q, ud_q;
  logic              neg_q, done_q;
  logic [CMP_W-1:0]  rem_q, dsh_q;
  logic [QUO_W-1:0]  qb_q;
  logic [CNT_W-1:0]  cnt_q;
  logic signed [QUO_W-1:0] q_q;

  assign done_o = done_q;
  assign q_o    = q_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      un_q    <= '0;
      ud_q    <= '0;
      neg_q   <= 1'b0;
      done_q  <= 1'b0;
      rem_q   <= '0;
      dsh_q   <= '0;
      qb_q    <= '0;
      cnt_q   <= '0;
      q_q     <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        D_IDLE: begin
          if (start_i) begin
            un_q    <= num_i[R_W-1] ? R_W'(-num_i) : num_i;
            ud_q    <= den_i[R_W-1] ? R_W'(-den_i) : den_i;
            neg_q   <= num_i[R_W-1] ^ den_i[R_W-1];
            state_q <= D_LOAD;
          end
        end
        D_LOAD: begin
          rem_q   <= CMP_W'({un_q, {(FRAC_BITS+1){1'b0}}}) + CMP_W'(ud_q);
          dsh_q   <= CMP_W'({ud_q, 1'b0}) << (QUO_W - 1);
          qb_q    <= '0;
          cnt_q   <= CNT_W'(QUO_W - 1);
          state_q <= D_ITER;
        end
        D_ITER: begin
          if (rem_q >= dsh_q) begin
            rem_q <= rem_q - dsh_q;
            qb_q  <= {qb_q[QUO_W-2:0], 1'b1};
          end else begin
            qb_q  <= {qb_q[QUO_W-2:0], 1'b0};
          end
          dsh_q <= dsh_q >> 1;
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == '0) begin
            state_q <= D_FIN;
          end
        end
        D_FIN: begin
          if (qb_q[QUO_W-1]) begin
            q_q <= neg_q ? {1'b1, {(QUO_W-1){1'b0}}} : {1'b0, {(QUO_W-1){1'b1}}};
          end else begin
            q_q <= neg_q ? QUO_W'(-qb_q) : qb_q;
          end
          done_q  <= 1'b1;
          state_q <= D_IDLE;
        end
        default: state_q <= D_IDLE;
      endcase
    end
  end

endmodule

// ===== design/vps_back.sv =====
// vps_back: executes queued commands: coefficient stores, combined matrix
// rebuild, transform, divide, viewport map, result register.
// Uses vps_pkg, vps_out_if, vps_mul, vps_div.
module vps_back import vps_pkg::*; #(
  parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF,
  parameter int unsigned COEF_WIDTH = COEF_WIDTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_valid_i,
  output logic      cmd_ready_o,
  input  cmd_t      cmd_i,
  input  viewport_t vp_i,
  vps_out_if.source out_ch
);

  typedef enum logic [3:0] {
    S_IDLE, S_CMB_MUL, S_CMB_WAIT, S_CMB_WR, S_XF_MUL, S_XF_WAIT, S_DIV_CHK,
    S_DIV_GO, S_DIV_WAIT, S_VP_MUL, S_VP_WAIT, S_VP_FIN, S_DEPTH, S_OUT
  } state_e;

  localparam logic signed [PROD_W-1:0] ONE   = PROD_W'(1);
  localparam logic signed [PROD_W-1:0] ONE_F = PROD_W'(1) << FRAC_BITS;
  localparam logic signed [PROD_W-1:0] RND_F = PROD_W'(1) << (FRAC_BITS - 1);

  state_e                    state_q;
  logic signed [COEF_WIDTH-1:0] mv_q [16];
  logic signed [COEF_WIDTH-1:0] pr_q [16];
  logic signed [OP_W-1:0]    comb_q [16];
  logic signed [R_W-1:0]     r_q [4];
  logic signed [QUO_W-1:0]   ndc_q [3];
  logic                      dirty_q, vsel_q, wz_q;
  logic [1:0]                ri_q, cj_q, ck_q, dn_q;
  logic signed [WORD_W-1:0]  px_q, py_q, pz_q, sx_q, sy_q, dz_q;
  logic signed [PROD_W-1:0]  acc_q;
  logic                      out_valid_q, out_wz_q;
  logic signed [WORD_W-1:0]  out_sx_q, out_sy_q, out_dz_q;

  logic                      mul_start, mul_done, div_start, div_done;
  logic signed [OP_W-1:0]    mul_a, mul_b, coef64, comb_rd;
  logic signed [PROD_W-1:0]  mul_p;
  logic signed [QUO_W-1:0]   div_q;
  logic [COEF_WIDTH-1:0]     coef_new;
  logic signed [WORD_W-1:0]  pj;
  logic signed [COEF_WIDTH-1:0] pr_rd, mv_rd;
  logic [VP_W-1:0]           size;
  logic signed [CFG_W-1:0]   org;
  logic signed [PROD_W-1:0]  cmb_rnd, cmb_sh, cterm, xf_sum, size_f, vt;
  logic signed [PROD_W-1:0]  vh_in, vh, org_f, vsum, dsum, dh_in, dh;

  assign coef64   = {{(OP_W-WORD_W){cmd_i.a[WORD_W-1]}}, cmd_i.a};
  assign coef_new = coef64[COEF_WIDTH-1:0];
  assign pr_rd    = pr_q[{ri_q, ck_q}];
  assign mv_rd    = mv_q[{ck_q, cj_q}];
  assign comb_rd  = comb_q[{ri_q, cj_q}];
  assign size     = vsel_q ? vp_i.height : vp_i.width;
  assign org      = vsel_q ? vp_i.origin_y : vp_i.origin_x;

  always_comb begin
    case (cj_q)
      2'd0:    pj = px_q;
      2'd1:    pj = py_q;
      default: pj = pz_q;
    endcase
  end

  always_comb begin
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    case (state_q)
      S_CMB_MUL: begin
        mul_start = 1'b1;
        mul_a     = {{(OP_W-COEF_WIDTH){pr_rd[COEF_WIDTH-1]}}, pr_rd};
        mul_b     = {{(OP_W-COEF_WIDTH){mv_rd[COEF_WIDTH-1]}}, mv_rd};
      end
      S_XF_MUL: begin
        mul_start = cj_q != 2'd3;
        mul_a     = comb_rd;
        mul_b     = {{(OP_W-WORD_W){pj[WORD_W-1]}}, pj};
      end
      S_VP_MUL: begin
        mul_start = 1'b1;
        mul_a     = {{(OP_W-VP_W){1'b0}}, size};
        mul_b     = vsel_q ? ndc_q[1] : ndc_q[0];
      end
      default: ;
    endcase
  end

  assign div_start = state_q == S_DIV_GO;

  // matrix product rounding, transform constant column, viewport and depth
  assign cmb_rnd = acc_q + RND_F;
  assign cmb_sh  = cmb_rnd >>> FRAC_BITS;
  assign cterm   = {{(PROD_W-OP_W){comb_rd[OP_W-1]}}, comb_rd} <<< FRAC_BITS;
  assign xf_sum  = acc_q + cterm;
  assign size_f  = {{(PROD_W-VP_W){1'b0}}, size} << FRAC_BITS;
  assign vt      = mul_p + size_f;
  assign vh_in   = acc_q + ONE;
  assign vh      = vh_in >>> 1;
  assign org_f   = {{(PROD_W-CFG_W){org[CFG_W-1]}}, org} <<< FRAC_BITS;
  assign vsum    = vh + org_f;
  assign dsum    = {{(PROD_W-QUO_W){ndc_q[2][QUO_W-1]}}, ndc_q[2]} + ONE_F;
  assign dh_in   = dsum + ONE;
  assign dh      = dh_in >>> 1;

  assign cmd_ready_o       = state_q == S_IDLE;
  assign out_ch.valid      = out_valid_q;
  assign out_ch.screen_x   = out_sx_q;
  assign out_ch.screen_y   = out_sy_q;
  assign out_ch.depth_value = out_dz_q;
  assign out_ch.w_zero     = out_wz_q;

  vps_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  vps_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (r_q[dn_q]),
    .den_i   (r_q[3]),
    .done_o  (div_done),
    .q_o     (div_q)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      for (int i = 0; i < 16; i++) begin
        mv_q[i]   <= '0;
        pr_q[i]   <= '0;
        comb_q[i] <= '0;
      end
      for (int i = 0; i < 4; i++) begin
        r_q[i]    <= '0;
      end
      for (int i = 0; i < 3; i++) begin
        ndc_q[i]  <= '0;
      end
      dirty_q     <= 1'b1;
      vsel_q      <= 1'b0;
      wz_q        <= 1'b0;
      ri_q        <= '0;
      cj_q        <= '0;
      ck_q        <= '0;
      dn_q        <= '0;
      px_q        <= '0;
      py_q        <= '0;
      pz_q        <= '0;
      sx_q        <= '0;
      sy_q        <= '0;
      dz_q        <= '0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
      out_wz_q    <= 1'b0;
      out_sx_q    <= '0;
      out_sy_q    <= '0;
      out_dz_q    <= '0;
    end else begin
      if (out_valid_q && out_ch.ready && state_q != S_OUT) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            if (cmd_i.kind == CMD_LOAD) begin
              if (cmd_i.mat_sel) begin
                pr_q[cmd_i.idx] <= coef_new;
              end else begin
                mv_q[cmd_i.idx] <= coef_new;
              end
              dirty_q <= 1'b1;
            end else begin
              px_q    <= cmd_i.a;
              py_q    <= cmd_i.b;
              pz_q    <= cmd_i.c;
              ri_q    <= '0;
              cj_q    <= '0;
              ck_q    <= '0;
              acc_q   <= '0;
              state_q <= dirty_q ? S_CMB_MUL : S_XF_MUL;
            end
          end
        end
        S_CMB_MUL: state_q <= S_CMB_WAIT;
        S_CMB_WAIT: begin
          if (mul_done) begin
            acc_q   <= acc_q + mul_p;
            ck_q    <= ck_q + 1'b1;
            state_q <= (ck_q == 2'd3) ? S_CMB_WR : S_CMB_MUL;
          end
        end
        S_CMB_WR: begin
          comb_q[{ri_q, cj_q}] <= sat64(cmb_sh);
          acc_q                <= '0;
          {ri_q, cj_q}         <= {ri_q, cj_q} + 1'b1;
          if ({ri_q, cj_q} == 4'hF) begin
            dirty_q <= 1'b0;
            state_q <= S_XF_MUL;
          end else begin
            state_q <= S_CMB_MUL;
          end
        end
        S_XF_MUL: begin
          if (cj_q == 2'd3) begin
            r_q[ri_q] <= xf_sum[R_W-1:0];
            acc_q     <= '0;
            cj_q      <= '0;
            ri_q      <= ri_q + 1'b1;
            if (ri_q == 2'd3) begin
              state_q <= S_DIV_CHK;
            end
          end else begin
            state_q <= S_XF_WAIT;
          end
        end
        S_XF_WAIT: begin
          if (mul_done) begin
            acc_q   <= acc_q + mul_p;
            cj_q    <= cj_q + 1'b1;
            state_q <= S_XF_MUL;
          end
        end
        S_DIV_CHK: begin
          dn_q <= '0;
          if (r_q[3] == '0) begin
            sx_q    <= '0;
            sy_q    <= '0;
            dz_q    <= '0;
            wz_q    <= 1'b1;
            state_q <= S_OUT;
          end else begin
            wz_q    <= 1'b0;
            state_q <= S_DIV_GO;
          end
        end
        S_DIV_GO: state_q <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (div_done) begin
            ndc_q[dn_q] <= div_q;
            dn_q        <= dn_q + 1'b1;
            if (dn_q == 2'd2) begin
              vsel_q  <= 1'b0;
              state_q <= S_VP_MUL;
            end else begin
              state_q <= S_DIV_GO;
            end
          end
        end
        S_VP_MUL: state_q <= S_VP_WAIT;
        S_VP_WAIT: begin
          if (mul_done) begin
            acc_q   <= vt;
            state_q <= S_VP_FIN;
          end
        end
        S_VP_FIN: begin
          if (vsel_q) begin
            sy_q    <= sat32(vsum);
            state_q <= S_DEPTH;
          end else begin
            sx_q    <= sat32(vsum);
            vsel_q  <= 1'b1;
            state_q <= S_VP_MUL;
          end
        end
        S_DEPTH: begin
          dz_q    <= sat32(dh);
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_q || out_ch.ready) begin
            out_valid_q <= 1'b1;
            out_sx_q    <= sx_q;
            out_sy_q    <= sy_q;
            out_dz_q    <= dz_q;
            out_wz_q    <= wz_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== design/vertex_project_to_screen.sv =====
// vertex_project_to_screen: top level; viewport registers, front stage,
// command queue and back engine. Uses vps_pkg, vps_if, vps_front, vps_fifo, vps_back.
//
//   channel  dir  transfer carries
//   in_ch    in   mode, matrix_select, coef_index, coef_value, point_x/y/z
//   out_ch   out  screen_x, screen_y, depth_value, w_zero
//   cfg      in   cfg_we_i, cfg_idx_i, cfg_data_i (write only)
//
// Coefficient loads pass the front register and the queue; the first point after
// any load rebuilds the combined matrix, 64 products on the shared multiplier.
// A point takes 14 products on the shared 32x32 multiplier plus three 64-step
// divides on the shared divider; w of zero skips the divides and viewport map.
// Reset is asynchronous, active low; matrices clear to zero, viewport to 0,0,640,480.
// Input keeps flowing into the queue, until it fills, while a result waits on out_ch.
module vertex_project_to_screen import vps_pkg::*; #(
  parameter int unsigned FRAC_BITS   = FRAC_BITS_DEF,
  parameter int unsigned COEF_WIDTH  = COEF_WIDTH_DEF,
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  cfg_reg_e         cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  vps_in_if.sink           in_ch,
  vps_out_if.source        out_ch
);

  viewport_t vp_q;
  logic      push_valid, push_ready, pop_valid, pop_ready;
  cmd_t      push_cmd, pop_cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q.origin_x <= '0;
      vp_q.origin_y <= '0;
      vp_q.width    <= VP_WIDTH_RST;
      vp_q.height   <= VP_HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ORIGIN_X: vp_q.origin_x <= cfg_data_i;
        REG_ORIGIN_Y: vp_q.origin_y <= cfg_data_i;
        REG_WIDTH:    vp_q.width    <= cfg_data_i[VP_W-1:0];
        REG_HEIGHT:   vp_q.height   <= cfg_data_i[VP_W-1:0];
        default: ;
      endcase
    end
  end

  vps_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_ch        (in_ch),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_cmd_o   (push_cmd)
  );

  vps_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_cmd_o    (pop_cmd)
  );

  vps_back #(.FRAC_BITS(FRAC_BITS), .COEF_WIDTH(COEF_WIDTH)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (pop_valid),
    .cmd_ready_o (pop_ready),
    .cmd_i       (pop_cmd),
    .vp_i        (vp_q),
    .out_ch      (out_ch)
  );

endmodule

// ===== design/vps_checker.sv =====
// vps_props: port-level checks of the vertex projection block, bound to the
// top level. Depends on vertex_project_to_screen and its interfaces.
module vps_props (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] screen_x_i,
  input logic [31:0] screen_y_i,
  input logic [31:0] depth_value_i,
  input logic        w_zero_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(screen_x_i) && $stable(screen_y_i) &&
      $stable(depth_value_i) && $stable(w_zero_i))
    else $error("result changed while stalled");

  a_wzero_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && w_zero_i |-> screen_x_i == '0 && screen_y_i == '0 &&
      depth_value_i == '0)
    else $error("zero-w result carries nonzero coordinates");

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_i)
    else $error("result offered during reset");

endmodule

bind vertex_project_to_screen vps_props u_vps_props (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_ch.valid),
  .out_ready_i   (out_ch.ready),
  .screen_x_i    (out_ch.screen_x),
  .screen_y_i    (out_ch.screen_y),
  .depth_value_i (out_ch.depth_value),
  .w_zero_i      (out_ch.w_zero)
);

// ===== bench/vps_checker.sv =====
// vps_checker: watches the input, output and register ports of the vertex projection
// block, predicts each screen point and compares it field by field. Uses vps_pkg, vps_if.
`timescale 1ns / 100ps
module vps_checker import vps_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  cfg_reg_e         cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  vps_in_if                in_mon,
  vps_out_if               out_mon,
  output int               fail_cnt_o,
  output int               pending_o,
  output int               in_xfers_o
);

  typedef logic signed [127:0] acc_t;

  typedef struct packed {
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [31:0] depth;
    logic               wz;
  } screen_pt_t;

  logic signed [31:0] modelview[16];
  logic signed [31:0] projection[16];
  viewport_t          vp;
  screen_pt_t         expected_pts[$];

  function automatic acc_t clamp(acc_t v, int bits);
    acc_t hi;
    hi = v >>> (bits - 1);
    if (hi == '0 || hi == '1) return v;
    return v[127] ? -(acc_t'(1) <<< (bits - 1)) : (acc_t'(1) <<< (bits - 1)) - 1;
  endfunction

  function automatic acc_t to_window(acc_t ndc, logic [VP_W-1:0] size,
                                     logic signed [CFG_W-1:0] origin);
    acc_t t;
    t = acc_t'(size) * ndc + (acc_t'(size) <<< 16);
    t = (t + 1) >>> 1;
    t = t + (acc_t'(origin) <<< 16);
    return clamp(t, 32);
  endfunction

  function automatic screen_pt_t project(logic signed [31:0] px, logic signed [31:0] py,
                                         logic signed [31:0] pz);
    acc_t       comb[16];
    acc_t       pt[4];
    acc_t       r[4];
    acc_t       ndc[3];
    acc_t       acc;
    logic [127:0] un, ud, q;
    screen_pt_t res;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        acc = '0;
        for (int k = 0; k < 4; k++) begin
          acc = acc + acc_t'(projection[i*4+k]) * acc_t'(modelview[k*4+j]);
        end
        comb[i*4+j] = clamp((acc + 32768) >>> 16, 64);
      end
    end
    pt[0] = acc_t'(px);
    pt[1] = acc_t'(py);
    pt[2] = acc_t'(pz);
    pt[3] = acc_t'(65536);
    for (int i = 0; i < 4; i++) begin
      r[i] = '0;
      for (int j = 0; j < 4; j++) begin
        r[i] = r[i] + comb[i*4+j] * pt[j];
      end
    end
    if (r[3] == '0) begin
      res = '{sx: '0, sy: '0, depth: '0, wz: 1'b1};
      return res;
    end
    for (int i = 0; i < 3; i++) begin
      un = r[i][127] ? -(r[i] <<< 16) : (r[i] <<< 16);
      ud = r[3][127] ? -r[3] : r[3];
      q  = (2 * un + ud) / (2 * ud);
      if (r[i][127] != r[3][127]) q = -q;
      ndc[i] = clamp(acc_t'(q), 64);
    end
    acc = to_window(ndc[0], vp.width, vp.origin_x);
    res.sx = acc[31:0];
    acc = to_window(ndc[1], vp.height, vp.origin_y);
    res.sy = acc[31:0];
    acc = clamp((ndc[2] + 65536 + 1) >>> 1, 32);
    res.depth = acc[31:0];
    res.wz = 1'b0;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    screen_pt_t exp_pt;
    if (!rst_ni) begin
      foreach (modelview[i]) modelview[i] <= '0;
      foreach (projection[i]) projection[i] <= '0;
      vp <= '{origin_x: '0, origin_y: '0, width: VP_WIDTH_RST, height: VP_HEIGHT_RST};
      expected_pts.delete();
      fail_cnt_o <= 0;
      pending_o  <= 0;
      in_xfers_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_ORIGIN_X: vp.origin_x <= cfg_data_i;
          REG_ORIGIN_Y: vp.origin_y <= cfg_data_i;
          REG_WIDTH:    vp.width    <= cfg_data_i[VP_W-1:0];
          REG_HEIGHT:   vp.height   <= cfg_data_i[VP_W-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        in_xfers_o <= in_xfers_o + 1;
        if (in_mon.mode == CMD_LOAD) begin
          if (in_mon.matrix_select) projection[in_mon.coef_index] <= in_mon.coef_value;
          else modelview[in_mon.coef_index] <= in_mon.coef_value;
        end else begin
          expected_pts.push_back(project(in_mon.point_x, in_mon.point_y, in_mon.point_z));
        end
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_pts.size() == 0) begin
          $error("unexpected result transfer");
          fail_cnt_o <= fail_cnt_o + 1;
        end else begin
          exp_pt = expected_pts.pop_front();
          if (out_mon.screen_x !== exp_pt.sx || out_mon.screen_y !== exp_pt.sy ||
              out_mon.depth_value !== exp_pt.depth || out_mon.w_zero !== exp_pt.wz) begin
            fail_cnt_o <= fail_cnt_o + 1;
          end
          if (out_mon.screen_x !== exp_pt.sx)
            $error("screen_x: expected %0d, actual %0d", exp_pt.sx, out_mon.screen_x);
          if (out_mon.screen_y !== exp_pt.sy)
            $error("screen_y: expected %0d, actual %0d", exp_pt.sy, out_mon.screen_y);
          if (out_mon.depth_value !== exp_pt.depth)
            $error("depth_value: expected %0d, actual %0d", exp_pt.depth,
                   out_mon.depth_value);
          if (out_mon.w_zero !== exp_pt.wz)
            $error("w_zero: expected %0d, actual %0d", exp_pt.wz, out_mon.w_zero);
        end
      end
      pending_o <= expected_pts.size();
    end
  end

endmodule

// ===== bench/tb_vertex_project_to_screen.sv =====
// tb_vertex_project_to_screen: drives coefficient loads, points and viewport settings
// into the projection block under random stalls; vps_checker does the checking.
`timescale 1ns / 100ps
module tb_vertex_project_to_screen;
  import vps_pkg::*;

  localparam int IdleLimit = 5000;
  localparam int SettleCycles = 20;
  localparam logic signed [31:0] One = 32'sh0001_0000;
  localparam logic signed [31:0] MaxV = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] MinV = 32'sh8000_0000;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we;
  cfg_reg_e         cfg_idx;
  logic [CFG_W-1:0] cfg_data;
  int               fail_cnt, pending, in_xfers;
  int               idle_cycles = 0;
  bit               calm = 1'b0;

  vps_in_if  in_ch();
  vps_out_if out_ch();

  vertex_project_to_screen i_dut (
    .clk_i, .rst_ni, .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  vps_checker i_checker (
    .clk_i, .rst_ni, .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_mon(in_ch), .out_mon(out_ch), .fail_cnt_o(fail_cnt), .pending_o(pending),
    .in_xfers_o(in_xfers)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    cfg_we = 1'b0;
    cfg_idx = REG_ORIGIN_X;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.mode = CMD_LOAD;
    in_ch.matrix_select = 1'b0;
    in_ch.coef_index = '0;
    in_ch.coef_value = '0;
    in_ch.point_x = '0;
    in_ch.point_y = '0;
    in_ch.point_z = '0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!calm && $urandom_range(5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk_i);
      end
      out_ch.ready <= 1'b1;
    end
  end

  function automatic logic signed [31:0] rand_coef();
    case ($urandom_range(7))
      0: return $urandom;
      1: case ($urandom_range(3))
           0: return MinV;
           1: return MaxV;
           2: return '0;
           default: return One;
         endcase
      default: return $signed($urandom_range(0, 8 * 65536)) - 4 * 65536;
    endcase
  endfunction

  function automatic logic signed [31:0] rand_coord();
    if ($urandom_range(5) == 0) return $urandom;
    return $signed($urandom_range(0, 2000 * 65536)) - 1000 * 65536;
  endfunction

  task automatic send(cmd_kind_e kind, logic sel, logic [3:0] idx, logic signed [31:0] coef,
                      logic signed [31:0] x, logic signed [31:0] y, logic signed [31:0] z);
    int target;
    if (!calm && $urandom_range(3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode <= kind;
    in_ch.matrix_select <= sel;
    in_ch.coef_index <= idx;
    in_ch.coef_value <= coef;
    in_ch.point_x <= x;
    in_ch.point_y <= y;
    in_ch.point_z <= z;
    target = in_xfers + 1;
    do @(negedge clk_i); while (in_xfers < target);
  endtask

  task automatic load(logic sel, logic [3:0] idx, logic signed [31:0] coef);
    send(CMD_LOAD, sel, idx, coef, $urandom, $urandom, $urandom);
  endtask

  task automatic point(logic signed [31:0] x, logic signed [31:0] y, logic signed [31:0] z);
    send(CMD_POINT, 1'($urandom), 4'($urandom), $urandom, x, y, z);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_viewport(logic [15:0] ox, logic [15:0] oy, logic [15:0] w,
                              logic [15:0] h);
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
  endtask

  initial begin
    int sent;
    int phase_end;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    set_viewport(16'd0, 16'd0, 16'd640, 16'd480);

    // zero matrices give w of zero
    point(One, -One, One);
    for (int i = 0; i < 4; i++) begin
      load(1'b0, 4'(i * 5), One);
      load(1'b1, 4'(i * 5), One);
    end
    point('0, '0, '0);
    point(One, -One, One / 2);
    point(MaxV, MinV, MaxV);
    point(MinV, MaxV, '0);
    load(1'b1, 4'd15, '0);
    point(One, One, One);
    load(1'b1, 4'd15, MinV);
    load(1'b1, 4'd14, MaxV);
    point(One, -One, MaxV);
    load(1'b0, 4'd3, MaxV);
    load(1'b0, 4'd0, MinV);
    point(-One, One, MinV);
    point(32'sd1, -32'sd1, 32'sd3);
    drain();

    sent = 0;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: set_viewport(16'h8000, 16'h7FFF, 16'h7FFF, 16'h0000);
        1: set_viewport(16'h7FFF, 16'h8000, 16'h0000, 16'h7FFF);
        default: set_viewport(16'($urandom), 16'($urandom), 16'($urandom_range(0, 32767)),
                               16'($urandom_range(0, 32767)));
      endcase
      phase_end = sent + 175;
      while (sent < phase_end) begin
        if (phase == 3 && sent > 600) calm = 1'b1;
        if ($urandom_range(9) == 0) begin
          if ($urandom_range(1)) load(1'($urandom), 4'($urandom), rand_coef());
          else point(rand_coord(), rand_coord(), rand_coord());
          sent++;
        end else begin
          repeat ($urandom_range(1, 6)) begin
            load(1'($urandom), 4'($urandom), rand_coef());
            sent++;
          end
          repeat ($urandom_range(1, 8)) begin
            point(rand_coord(), rand_coord(), rand_coord());
            sent++;
          end
        end
      end
      drain();
    end

    if (fail_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
